### rtl/core/round_robin_sleep_scheduler_macros.svh
// Assertion helpers for the round-robin sleep scheduler.
`ifndef ROUND_ROBIN_SLEEP_SCHEDULER_MACROS_SVH
`define ROUND_ROBIN_SLEEP_SCHEDULER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define RRSS_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("round_robin_sleep_scheduler: assertion failed");

// Next-cycle implication, checked outside reset.
`define RRSS_ASSERT_NXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("round_robin_sleep_scheduler: assertion failed");

`endif

### rtl/core/rrss_pkg.sv
package rrss_pkg;

    // Field widths
    localparam int CMD_W     = 2;
    localparam int SECS_W    = 17;
    localparam int RATE_W    = 10;
    localparam int TICK_W    = 27;
    localparam int PID_OUT_W = 3;
    localparam int PROD_W    = SECS_W + RATE_W;

    // Configuration port
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 27;

    // Stream payload layout
    localparam int IN_TDATA_W      = 24;
    localparam int OUT_TDATA_W     = 40;
    localparam int OUT_OLD_LSB     = 0;
    localparam int OUT_NEW_LSB     = 3;
    localparam int OUT_CREATED_LSB = 6;
    localparam int OUT_STATUS_BIT  = 9;
    localparam int OUT_TIME_LSB    = 10;

    // Defaults and reset values
    localparam int DEFAULT_NUM_PROCS = 8;
    localparam logic [RATE_W-1:0] RATE_RESET  = RATE_W'(50);
    localparam logic [TICK_W-1:0] DAY_RESET   = TICK_W'(4320000);
    localparam logic [TICK_W-1:0] LATE_RESET  = TICK_W'(3420000);
    localparam logic [TICK_W-1:0] EARLY_RESET = TICK_W'(180050);
    localparam logic [TICK_W-1:0] TICK_RESET  = TICK_W'(4319600);

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_RATE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DAY   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LATE  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_EARLY = 2'd3;

    typedef enum logic [1:0] {
        PS_READY    = 2'd0,
        PS_RUNNING  = 2'd1,
        PS_SLEEPING = 2'd2,
        PS_DEAD     = 2'd3
    } t_pstate;

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK   = 2'd0,
        CMD_SLEEP  = 2'd1,
        CMD_EXIT   = 2'd2,
        CMD_CREATE = 2'd3
    } t_cmd;

    typedef struct packed {
        logic take;
        logic tick_adv;
        logic mul_load;
        logic rem_start;
        logic sleep_wr;
        logic exit_wr;
        logic create_exec;
        logic scan_init;
        logic scan_run;
        logic search_init;
        logic search_run;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        t_cmd cmd;
        logic rem_busy;
        logic scan_done;
        logic found;
        logic out_space;
    } t_dp_stat;

endpackage

### rtl/core/rrss_rem.sv
// Restoring remainder unit: one dividend bit per cycle.
module rrss_rem import rrss_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [TICK_W:0]   i_dividend,
    input  logic [TICK_W:0]   i_divisor,
    output logic              o_busy,
    output logic [TICK_W-1:0] o_rem
);

    localparam int DVD_W = TICK_W + 1;
    localparam int CNT_W = $clog2(DVD_W + 1);

    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic [DVD_W-1:0] r_dvd;
    logic [DVD_W-1:0] r_dvs;
    logic [DVD_W-1:0] r_rem;
    logic [DVD_W:0]   trial;
    logic [DVD_W-1:0] n_rem;

    always_comb begin
        trial = {r_rem, r_dvd[DVD_W-1]};
        if (trial >= {1'b0, r_dvs}) begin
            n_rem = DVD_W'(trial - {1'b0, r_dvs});
        end else begin
            n_rem = trial[DVD_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(DVD_W);
        end else if (r_busy) begin
            r_cnt  <= r_cnt - 1'b1;
            r_busy <= (r_cnt != CNT_W'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_dvs <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[DVD_W-2:0], 1'b0};
            r_rem <= n_rem;
        end
    end

    // Remainder stays below the divisor, which never exceeds 2^27.
    assign o_busy = r_busy;
    assign o_rem  = r_rem[TICK_W-1:0];

endmodule

### rtl/core/rrss_dp.sv
// Scheduler datapath: configuration, time, process table and result register.
module rrss_dp import rrss_pkg::*; #(
    parameter int NUM_PROCS = DEFAULT_NUM_PROCS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]   i_cfg_addr,
    input  logic [CFG_W-1:0]       i_cfg_wdata,
    input  logic [IN_TDATA_W-1:0]  i_in_data,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic [OUT_TDATA_W-1:0] o_out_data,
    input  t_dp_cmd                i_cmd,
    output t_dp_stat               o_stat
);

    localparam int PID_W = $clog2(NUM_PROCS);
    localparam int CNT_W = $clog2(NUM_PROCS + 1);
    localparam int DAY_W = TICK_W + 1;
    localparam logic [PID_W-1:0] LAST_PID = PID_W'(NUM_PROCS - 1);
    localparam logic [CNT_W-1:0] PROC_CNT = CNT_W'(NUM_PROCS);

    function automatic logic [PID_W-1:0] pid_inc(input logic [PID_W-1:0] p);
        return (p == LAST_PID) ? '0 : PID_W'(p + 1'b1);
    endfunction

    // Configuration
    logic [RATE_W-1:0] r_rate;
    logic [TICK_W-1:0] r_day;
    logic [TICK_W-1:0] r_late;
    logic [TICK_W-1:0] r_early;

    // Scheduler state
    logic [TICK_W-1:0] r_tick;
    logic [PID_W-1:0]  r_cur;
    logic [CNT_W-1:0]  r_created_cnt;

    // Item in flight
    t_cmd              r_cmd;
    logic [SECS_W-1:0] r_secs;
    logic [PID_W-1:0]  r_old;
    logic [PROD_W-1:0] r_prod;
    logic [PID_W-1:0]  r_created;
    logic              r_refused;
    logic              r_late_ok;

    // Process table
    t_pstate           r_st_mem [NUM_PROCS];
    logic [TICK_W-1:0] r_wk_mem [NUM_PROCS];
    logic [NUM_PROCS-1:0] r_st_valid;
    logic [NUM_PROCS-1:0] r_wk_valid;
    logic [PID_W-1:0]  r_idx;
    logic              r_rd_ok;
    logic [PID_W-1:0]  r_rd_addr;
    t_pstate           r_rd_st;
    logic [TICK_W-1:0] r_rd_wk;
    logic              r_rd_vs;
    logic              r_rd_vw;

    // Result
    logic                   r_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_data;

    logic [DAY_W-1:0]  day_len;
    logic [DAY_W-1:0]  tick_inc;
    logic [TICK_W-1:0] tick_next;
    logic [DAY_W-1:0]  dividend;
    logic [PROD_W-1:0] prod;
    t_pstate           st_q;
    logic [TICK_W-1:0] wk_q;
    logic              wake_hit;
    logic              cur_ready;
    logic              scan_act;
    logic              found;
    logic              take_found;
    logic              can_create;
    logic              rem_busy;
    logic [TICK_W-1:0] rem;
    logic              st_we;
    logic [PID_W-1:0]  st_waddr;
    t_pstate           st_wdata;

    // A zero day length means the full counter range.
    assign day_len   = {(r_day == '0), r_day};
    assign tick_inc  = {1'b0, r_tick} + DAY_W'(1);
    assign tick_next = (tick_inc >= day_len) ? '0 : tick_inc[TICK_W-1:0];
    assign dividend  = {1'b0, r_tick} + {1'b0, r_prod};
    assign prod      = PROD_W'(r_secs) * PROD_W'(r_rate);

    // Entries never written read as their reset values.
    assign st_q = r_rd_vs ? r_rd_st : ((r_rd_addr == '0) ? PS_RUNNING : PS_DEAD);
    assign wk_q = r_rd_vw ? r_rd_wk : '0;

    assign wake_hit   = (st_q == PS_SLEEPING) && (wk_q < r_tick) &&
                        (r_late_ok || (wk_q >= r_early));
    assign cur_ready  = (r_rd_addr == r_cur) && (st_q == PS_RUNNING);
    assign scan_act   = i_cmd.scan_run && r_rd_ok;
    assign found      = r_rd_ok && ((r_rd_addr == '0) || (st_q == PS_READY));
    assign take_found = i_cmd.search_run && found;
    assign can_create = (r_created_cnt < PROC_CNT);

    always_comb begin
        st_we    = 1'b0;
        st_waddr = r_cur;
        st_wdata = PS_READY;
        priority if (i_cmd.sleep_wr) begin
            st_we    = 1'b1;
            st_wdata = PS_SLEEPING;
        end else if (i_cmd.exit_wr) begin
            st_we    = 1'b1;
            st_wdata = PS_DEAD;
        end else if (scan_act && (wake_hit || cur_ready)) begin
            st_we    = 1'b1;
            st_waddr = r_rd_addr;
        end else if (take_found) begin
            st_we    = 1'b1;
            st_waddr = r_rd_addr;
            st_wdata = PS_RUNNING;
        end else if (i_cmd.create_exec && can_create) begin
            st_we    = 1'b1;
            st_waddr = r_created_cnt[PID_W-1:0];
        end
    end

    rrss_rem u_rem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.rem_start),
        .i_dividend (dividend),
        .i_divisor  (day_len),
        .o_busy     (rem_busy),
        .o_rem      (rem)
    );

    // Table storage and registered reads
    always_ff @(posedge i_clk) begin
        if (st_we) begin
            r_st_mem[st_waddr] <= st_wdata;
        end
        if (i_cmd.sleep_wr) begin
            r_wk_mem[r_cur] <= rem;
        end
        r_rd_st   <= r_st_mem[r_idx];
        r_rd_wk   <= r_wk_mem[r_idx];
        r_rd_addr <= r_idx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st_valid <= '0;
            r_wk_valid <= '0;
            r_rd_vs    <= 1'b0;
            r_rd_vw    <= 1'b0;
            r_rd_ok    <= 1'b0;
        end else begin
            if (st_we) begin
                r_st_valid[st_waddr] <= 1'b1;
            end
            // A woken slot's wake tick returns to zero.
            if (i_cmd.sleep_wr) begin
                r_wk_valid[r_cur] <= 1'b1;
            end else if (scan_act && wake_hit) begin
                r_wk_valid[r_rd_addr] <= 1'b0;
            end
            r_rd_vs <= r_st_valid[r_idx];
            r_rd_vw <= r_wk_valid[r_idx];
            r_rd_ok <= i_cmd.scan_run || i_cmd.search_run;
        end
    end

    // Configuration, time and process bookkeeping
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate        <= RATE_RESET;
            r_day         <= DAY_RESET;
            r_late        <= LATE_RESET;
            r_early       <= EARLY_RESET;
            r_tick        <= TICK_RESET;
            r_cur         <= '0;
            r_created_cnt <= CNT_W'(1);
            r_idx         <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                unique case (i_cfg_addr)
                    CFG_RATE:  r_rate  <= i_cfg_wdata[RATE_W-1:0];
                    CFG_DAY:   r_day   <= i_cfg_wdata[TICK_W-1:0];
                    CFG_LATE:  r_late  <= i_cfg_wdata[TICK_W-1:0];
                    CFG_EARLY: r_early <= i_cfg_wdata[TICK_W-1:0];
                endcase
            end
            if (i_cmd.tick_adv) begin
                r_tick <= tick_next;
            end
            if (i_cmd.create_exec && can_create) begin
                r_created_cnt <= r_created_cnt + 1'b1;
            end
            if (take_found) begin
                r_cur <= r_rd_addr;
            end
            priority if (i_cmd.scan_init) begin
                r_idx <= '0;
            end else if (i_cmd.search_init) begin
                r_idx <= pid_inc(r_cur);
            end else if (i_cmd.scan_run || i_cmd.search_run) begin
                r_idx <= pid_inc(r_idx);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_cmd     <= t_cmd'(i_in_data[CMD_W-1:0]);
            r_secs    <= i_in_data[CMD_W +: SECS_W];
            r_old     <= r_cur;
            r_created <= '0;
            r_refused <= 1'b0;
        end else if (i_cmd.create_exec) begin
            if (can_create) begin
                r_created <= r_created_cnt[PID_W-1:0];
            end else begin
                r_refused <= 1'b1;
            end
        end
        if (i_cmd.mul_load) begin
            r_prod <= prod;
        end
        if (i_cmd.scan_init) begin
            r_late_ok <= (r_tick < r_late);
        end
    end

    // Result register: hold until the transfer completes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_data <= OUT_TDATA_W'({r_tick, r_refused, PID_OUT_W'(r_created),
                                        PID_OUT_W'(r_cur), PID_OUT_W'(r_old)});
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_out_data       = r_out_data;
    assign o_stat.cmd       = r_cmd;
    assign o_stat.rem_busy  = rem_busy;
    assign o_stat.scan_done = r_rd_ok && (r_rd_addr == LAST_PID);
    assign o_stat.found     = found;
    assign o_stat.out_space = !r_out_valid || i_out_ready;

endmodule

### rtl/core/rrss_ctrl.sv
// Scheduler sequencer: one item at a time; all but create pass through wake scan and search.
module rrss_ctrl import rrss_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_EXEC,
        S_DIV_GO,
        S_DIV,
        S_SCAN_INIT,
        S_SCAN,
        S_SEARCH_INIT,
        S_SEARCH,
        S_RESULT
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.take = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                unique case (i_stat.cmd)
                    CMD_TICK: begin
                        o_cmd.tick_adv = 1'b1;
                        n_state        = S_SCAN_INIT;
                    end
                    CMD_SLEEP: begin
                        o_cmd.mul_load = 1'b1;
                        n_state        = S_DIV_GO;
                    end
                    CMD_EXIT: begin
                        o_cmd.exit_wr = 1'b1;
                        n_state       = S_SCAN_INIT;
                    end
                    CMD_CREATE: begin
                        o_cmd.create_exec = 1'b1;
                        n_state           = S_RESULT;
                    end
                endcase
            end
            S_DIV_GO: begin
                o_cmd.rem_start = 1'b1;
                n_state         = S_DIV;
            end
            S_DIV: begin
                if (!i_stat.rem_busy) begin
                    o_cmd.sleep_wr = 1'b1;
                    n_state        = S_SCAN_INIT;
                end
            end
            S_SCAN_INIT: begin
                o_cmd.scan_init = 1'b1;
                n_state         = S_SCAN;
            end
            S_SCAN: begin
                o_cmd.scan_run = 1'b1;
                if (i_stat.scan_done) begin
                    n_state = S_SEARCH_INIT;
                end
            end
            S_SEARCH_INIT: begin
                o_cmd.search_init = 1'b1;
                n_state           = S_SEARCH;
            end
            S_SEARCH: begin
                o_cmd.search_run = 1'b1;
                if (i_stat.found) begin
                    n_state = S_RESULT;
                end
            end
            S_RESULT: begin
                if (i_stat.out_space) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule

### rtl/core/round_robin_sleep_scheduler.sv
// Channel      Dir  Fields (lowest bit up)
// s_axis       in   tdata: cmd[1:0], sleep_seconds[18:2], zero fill to 24 bits
// m_axis       out  tdata: old_pid[2:0], new_pid[5:3], created_pid[8:6], status[9],
//                          time_ticks[36:10], zero fill to 40 bits
// i_cfg_*      in   write enable, register index (2 bits), write data (27 bits)
//
// Create goes straight to the result; tick and exit run the wake scan and the
// round-robin search, each walking the process table one slot a cycle through its
// registered read port; sleep adds the bit-serial day-length remainder before them.
// Reset is synchronous: slot 0 runs, all other slots read as dead, with no clearing pass.
// A finished result waits in the output register; the next item is taken meanwhile,
// and the sequencer stalls only when a second result is ready before the first is taken.
`include "round_robin_sleep_scheduler_macros.svh"

module round_robin_sleep_scheduler import rrss_pkg::*; #(
    parameter int NUM_PROCS = DEFAULT_NUM_PROCS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // Configuration write port
    input  logic                   i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]   i_cfg_addr,
    input  logic [CFG_W-1:0]       i_cfg_wdata,
    // Commands in
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // cmd, sleep_seconds
    // Results out
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata    // old_pid, new_pid, created_pid, status,
                                                   // time_ticks
);

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    // Sequencer: one command at a time
    rrss_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (dp_stat),
        .o_cmd      (dp_cmd)
    );

    // Datapath: time, process table, remainder unit and result register
    rrss_dp #(
        .NUM_PROCS (NUM_PROCS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_data   (s_axis_tdata),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_data  (m_axis_tdata),
        .i_cmd       (dp_cmd),
        .o_stat      (dp_stat)
    );

    // Drop ready right after a transfer: items never overlap.
    `RRSS_ASSERT_NXT(a_single_item, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)

    // Table walks start only after the remainder unit has finished.
    `RRSS_ASSERT_IMP(a_walk_after_rem, i_clk, i_rst_n, dp_cmd.scan_run || dp_cmd.search_run, !dp_stat.rem_busy)

    // A refused create leaves the running process in place.
    `RRSS_ASSERT_IMP(a_refused_keeps_pid, i_clk, i_rst_n, m_axis_tvalid && m_axis_tdata[OUT_STATUS_BIT], m_axis_tdata[OUT_OLD_LSB +: PID_OUT_W] == m_axis_tdata[OUT_NEW_LSB +: PID_OUT_W])

endmodule
